/* rtl/core/binary_conv3x3_xnor_popcount_defines.svh */
// Assertion macros for the binary 3x3 convolution block.
// BCX_ASSERT is disabled while reset is held; BCX_ASSERT_ALWAYS is not.
`ifndef BINARY_CONV3X3_XNOR_POPCOUNT_DEFINES_SVH
`define BINARY_CONV3X3_XNOR_POPCOUNT_DEFINES_SVH
`ifndef SYNTHESIS
`define BCX_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define BCX_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define BCX_ASSERT(lbl, prop, msg)
`define BCX_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* rtl/core/bcx_pkg.sv */
package bcx_pkg;

    // Image geometry and filter count
    localparam int IMG_WIDTH   = 24;
    localparam int IMG_HEIGHT  = 24;
    localparam int NUM_FILTERS = 16;
    localparam int IMG_SIZE    = IMG_WIDTH * IMG_HEIGHT;

    // Results released per accepted item while the image is flushed
    localparam int RESULT_CAP = 25;

    // Field widths
    localparam int WIN_W  = 9;
    localparam int THR_W  = 15;
    localparam int FIDX_W = 4;
    localparam int FEAT_W = 16;
    localparam int POS_W  = 10;

    // Filter lanes that can land in the feature word
    localparam int NUM_LANES = (NUM_FILTERS < FEAT_W) ? NUM_FILTERS : FEAT_W;

    // Line store: one column address, upper and lower row bit per entry
    localparam int COL_W  = $clog2(IMG_WIDTH);
    localparam int LINE_W = 2;

    // Opcodes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    // Filter entry write, applied where the window is evaluated
    typedef struct packed {
        logic              en;
        logic [FIDX_W-1:0] idx;
        logic [WIN_W-1:0]  weights;
        logic [THR_W-1:0]  thresh;
        logic              pol;
    } t_flt_wr;

endpackage

/* rtl/core/bcx_line_store.sv */
module bcx_line_store
    import bcx_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  logic [COL_W-1:0]  i_rd_addr,
    output logic [LINE_W-1:0] o_rd_data,
    input  logic              i_wr_en,
    input  logic [COL_W-1:0]  i_wr_addr,
    input  logic [LINE_W-1:0] i_wr_data
);

    // Bit 1: row two above, bit 0: row above
    logic [LINE_W-1:0] r_mem [IMG_WIDTH];
    logic [LINE_W-1:0] r_rd_data;

    // Write back and read, read data held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/core/bcx_filter_bank.sv */
module bcx_filter_bank
    import bcx_pkg::*;
(
    input  logic              i_clk,
    input  t_flt_wr           i_wr,
    input  logic [WIN_W-1:0]  i_window,
    output logic [FEAT_W-1:0] o_feature
);

    localparam int CNT_W = $clog2(WIN_W + 1);

    logic [WIN_W-1:0] r_weights [NUM_LANES];
    logic [THR_W-1:0] r_thresh  [NUM_LANES];
    logic             r_pol     [NUM_LANES];

    function automatic logic [CNT_W-1:0] ones(input logic [WIN_W-1:0] v);
        logic [CNT_W-1:0] c;
        c = '0;
        for (int i = 0; i < WIN_W; i++) begin
            c = c + CNT_W'(v[i]);
        end
        return c;
    endfunction

    // Store one filter entry; an index with no lane is dropped
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NUM_LANES; k++) begin
            if (i_wr.en && (i_wr.idx == FIDX_W'(k))) begin
                r_weights[k] <= i_wr.weights;
                r_thresh[k]  <= i_wr.thresh;
                r_pol[k]     <= i_wr.pol;
            end
        end
    end

    // XNOR, count matches and compare, all lanes in parallel
    always_comb begin
        logic [CNT_W-1:0] cnt;
        o_feature = '0;
        for (int k = 0; k < NUM_LANES; k++) begin
            cnt = ones(~(i_window ^ r_weights[k]));
            if (r_pol[k]) begin
                o_feature[k] = (THR_W'(cnt) >= r_thresh[k]);
            end else begin
                o_feature[k] = (THR_W'(cnt) <= r_thresh[k]);
            end
        end
    end

endmodule

/* rtl/core/binary_conv3x3_xnor_popcount.sv */
// Binary 3x3 convolution over a raster pixel stream, 16 XNOR/popcount filters
// evaluated in parallel. One input transfer (a filter load or a pixel) is taken
// per cycle; a result passes both stages and the output register after the pixel
// that completes its window, and output back-pressure stalls the pipe only when
// its two stages and the output register are all full. The rate is set by the
// line store, a single-port-per-direction memory that is read for one column per
// pixel and written back from stage one. Results start once a row plus one pixel
// has arrived. A pixel with tlast set, or the last pixel of the image, starts a
// flush of zero pixels that releases up to 25 results at one per cycle, unless
// the pipe stalls, for that transfer and for each later transfer of either kind
// (loads are applied before the batch they precede); input is not taken while a
// batch is still running. Rows left from an earlier image are masked by fill
// tracking, so there is no clearing pass after reset or between images.
`include "binary_conv3x3_xnor_popcount_defines.svh"

module binary_conv3x3_xnor_popcount
    import bcx_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [0] pixel, [4:1] filter_index, [13:5] weight_bits, [28:14] threshold,
    // [29] polarity, [31:30] zero
    input  logic [31:0] i_s_axis_tdata,
    // [0] opcode
    input  logic        i_s_axis_tuser,
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [15:0] feature_word, [25:16] position, [31:26] zero
    output logic [31:0] o_m_axis_tdata,
    output logic        o_m_axis_tlast
);

    localparam int PIX_CW  = $clog2(IMG_SIZE + IMG_WIDTH + 1);
    localparam int OUT_CW  = $clog2(IMG_SIZE);
    localparam int ROW_W   = $clog2(IMG_HEIGHT);
    localparam int CRED_W  = $clog2(RESULT_CAP + 1);
    localparam int OUT_PAD = 32 - POS_W - FEAT_W;

    localparam logic [PIX_CW-1:0] EMIT_LAG = PIX_CW'(IMG_WIDTH + 1);

    localparam logic [WIN_W-1:0] KEEP_ALL   = 9'h1FF;
    localparam logic [WIN_W-1:0] CUT_TOP    = 9'h1C0;
    localparam logic [WIN_W-1:0] CUT_BOTTOM = 9'h007;
    localparam logic [WIN_W-1:0] CUT_LEFT   = 9'h124;
    localparam logic [WIN_W-1:0] CUT_RIGHT  = 9'h049;

    // Input fields
    logic             in_op;
    logic             in_pixel;
    logic             in_last;
    t_flt_wr          in_wr;

    assign in_op    = i_s_axis_tuser;
    assign in_pixel = i_s_axis_tdata[0];
    assign in_last  = i_s_axis_tlast;

    // Front counters
    logic [PIX_CW-1:0] r_pix_cnt;
    logic [COL_W-1:0]  r_col;
    logic              r_lo_ok;
    logic              r_up_ok;
    logic [OUT_CW-1:0] r_out_cnt;
    logic [COL_W-1:0]  r_out_col;
    logic [ROW_W-1:0]  r_out_row;
    logic              r_drain;
    logic [CRED_W-1:0] r_credit;

    // Pipeline stages
    logic              r_s1_valid;
    t_flt_wr           r_s1_wr;
    logic              r_s1_pix;
    logic              r_s1_emit;
    logic              r_s1_lo_ok;
    logic              r_s1_up_ok;
    logic [COL_W-1:0]  r_s1_col;
    logic [WIN_W-1:0]  r_s1_keep;
    logic [POS_W-1:0]  r_s1_pos;
    logic              r_s1_last;

    logic [WIN_W-1:0]  r_window;
    logic [WIN_W-1:0]  n_window;

    logic              r_s2_valid;
    t_flt_wr           r_s2_wr;
    logic              r_s2_emit;
    logic [WIN_W-1:0]  r_s2_win;
    logic [POS_W-1:0]  r_s2_pos;
    logic              r_s2_last;

    logic              r_out_valid;
    logic [FEAT_W-1:0] r_out_feat;
    logic [POS_W-1:0]  r_out_pos;
    logic              r_out_last;

    // Handshake and flow
    logic              s_acc;
    logic              batch_busy;
    logic              gen_push;
    logic              in_push;
    logic              front_push;
    logic              front_emit;
    logic              push_pix;
    logic              out_at_end;
    logic              pix_at_end;
    logic [WIN_W-1:0]  keep;
    logic              out_free;
    logic              s2_go;
    logic              s2_free;
    logic              s1_go;
    logic              s1_free;

    logic [LINE_W-1:0] line_rd;
    logic              up_bit;
    logic              lo_bit;
    t_flt_wr           flt_wr;
    logic [FEAT_W-1:0] feature;

    // Stall chain from the output register back to the input
    assign out_free   = !r_out_valid || i_m_axis_tready;
    assign s2_go      = r_s2_valid && (!r_s2_emit || out_free);
    assign s2_free    = !r_s2_valid || s2_go;
    assign s1_go      = r_s1_valid && s2_free;
    assign s1_free    = !r_s1_valid || s2_free;

    // Hold input while a flush batch still has results to release
    assign batch_busy      = r_drain && (r_credit != '0);
    assign o_s_axis_tready = s1_free && !batch_busy;
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign gen_push        = batch_busy && s1_free;
    assign in_push         = s_acc && (in_op == OP_PIXEL) && !r_drain;
    assign front_push      = in_push || gen_push;
    assign push_pix        = gen_push ? 1'b0 : in_pixel;
    assign front_emit      = front_push && (r_pix_cnt >= EMIT_LAG);
    assign out_at_end      = (r_out_cnt == OUT_CW'(IMG_SIZE - 1));
    assign pix_at_end      = (r_pix_cnt >= PIX_CW'(IMG_SIZE - 1));

    // Filter write fields; an item that enters as a pixel carries no write
    assign in_wr    = '{en: !front_push,
                        idx: i_s_axis_tdata[4:1],
                        weights: i_s_axis_tdata[13:5],
                        thresh: i_s_axis_tdata[28:14],
                        pol: i_s_axis_tdata[29]};

    // Zero-padding mask for the position being produced
    always_comb begin
        keep = KEEP_ALL;
        if (r_out_row == '0) begin
            keep = keep & ~CUT_TOP;
        end
        if (r_out_row == ROW_W'(IMG_HEIGHT - 1)) begin
            keep = keep & ~CUT_BOTTOM;
        end
        if (r_out_col == '0) begin
            keep = keep & ~CUT_LEFT;
        end
        if (r_out_col == COL_W'(IMG_WIDTH - 1)) begin
            keep = keep & ~CUT_RIGHT;
        end
    end

    // Advance pixel and position counters, run flush batches
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix_cnt <= '0;
            r_col     <= '0;
            r_lo_ok   <= 1'b0;
            r_up_ok   <= 1'b0;
            r_out_cnt <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_drain   <= 1'b0;
            r_credit  <= '0;
        end else begin
            if (s_acc) begin
                r_credit <= CRED_W'(RESULT_CAP) - CRED_W'(front_emit);
            end else if (front_emit) begin
                r_credit <= r_credit - CRED_W'(1);
            end
            if (front_push) begin
                if (front_emit && out_at_end) begin
                    // image done: return to the start of a new image
                    r_pix_cnt <= '0;
                    r_col     <= '0;
                    r_lo_ok   <= 1'b0;
                    r_up_ok   <= 1'b0;
                    r_out_cnt <= '0;
                    r_out_col <= '0;
                    r_out_row <= '0;
                    r_drain   <= 1'b0;
                end else begin
                    r_pix_cnt <= r_pix_cnt + PIX_CW'(1);
                    if (r_col == COL_W'(IMG_WIDTH - 1)) begin
                        r_col   <= '0;
                        r_up_ok <= r_lo_ok;
                        r_lo_ok <= 1'b1;
                    end else begin
                        r_col <= r_col + COL_W'(1);
                    end
                    if (front_emit) begin
                        r_out_cnt <= r_out_cnt + OUT_CW'(1);
                        if (r_out_col == COL_W'(IMG_WIDTH - 1)) begin
                            r_out_col <= '0;
                            r_out_row <= r_out_row + ROW_W'(1);
                        end else begin
                            r_out_col <= r_out_col + COL_W'(1);
                        end
                    end
                    if (in_push && (in_last || pix_at_end)) begin
                        r_drain <= 1'b1;
                    end
                end
            end
        end
    end

    // Line store: read at entry, write back from stage one
    bcx_line_store u_line_store (
        .i_clk     (i_clk),
        .i_rd_en   (front_push),
        .i_rd_addr (r_col),
        .o_rd_data (line_rd),
        .i_wr_en   (s1_go && !r_s1_wr.en),
        .i_wr_addr (r_s1_col),
        .i_wr_data ({lo_bit, r_s1_pix})
    );

    // Drop rows not yet written in this image
    assign up_bit = line_rd[1] & r_s1_up_ok;
    assign lo_bit = line_rd[0] & r_s1_lo_ok;

    // Shift the window by one column
    assign n_window = {r_window[7:6], up_bit, r_window[4:3], lo_bit,
                       r_window[1:0], r_s1_pix};

    // Stage valids, window and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_window    <= '0;
        end else begin
            if (s1_free) begin
                r_s1_valid <= front_push || (s_acc && (in_op == OP_LOAD));
            end
            if (s2_free) begin
                r_s2_valid <= r_s1_valid;
            end
            if (s1_go && !r_s1_wr.en) begin
                r_window <= n_window;
            end
            if (out_free) begin
                r_out_valid <= s2_go && r_s2_emit;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge i_clk) begin
        if (s1_free) begin
            r_s1_wr    <= in_wr;
            r_s1_pix   <= push_pix;
            r_s1_emit  <= front_emit;
            r_s1_lo_ok <= r_lo_ok;
            r_s1_up_ok <= r_up_ok;
            r_s1_col   <= r_col;
            r_s1_keep  <= keep;
            r_s1_pos   <= POS_W'(r_out_cnt);
            r_s1_last  <= out_at_end;
        end
        if (s2_free) begin
            r_s2_wr   <= r_s1_wr;
            r_s2_emit <= r_s1_emit;
            r_s2_win  <= n_window & r_s1_keep;
            r_s2_pos  <= r_s1_pos;
            r_s2_last <= r_s1_last;
        end
        if (s2_go && r_s2_emit) begin
            r_out_feat <= feature;
            r_out_pos  <= r_s2_pos;
            r_out_last <= r_s2_last;
        end
    end

    // Filter loads take effect in the evaluation stage, in stream order
    always_comb begin
        flt_wr    = r_s2_wr;
        flt_wr.en = r_s2_valid && r_s2_wr.en;
    end

    bcx_filter_bank u_filter_bank (
        .i_clk     (i_clk),
        .i_wr      (flt_wr),
        .i_window  (r_s2_win),
        .o_feature (feature)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{OUT_PAD{1'b0}}, r_out_pos, r_out_feat};
    assign o_m_axis_tlast  = r_out_last;

    // A result enters exactly one row and one pixel behind the input
    `BCX_ASSERT(a_emit_lag, front_emit |-> (r_pix_cnt - PIX_CW'(r_out_cnt)) == EMIT_LAG, "emit lag")
    // A stalled stage one keeps its line store read data
    `BCX_ASSERT(a_rd_hold, r_s1_valid && !s2_free |=> $stable(line_rd), "line read lost")
    // A flush never runs on an empty image
    `BCX_ASSERT(a_drain_cnt, r_drain |-> r_pix_cnt != '0, "flush without pixels")

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
    import bcx_pkg::*;

    localparam int RAND_ITEMS     = 320;
    localparam int NO_IDLE_FROM   = 150;
    localparam int NO_IDLE_TO     = 280;
    localparam int TAIL_PIXELS    = 60;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES  = 20;
    localparam int LIMIT_NS       = 800_000;
    localparam int MAX_PRINTS     = 40;

    // One input transfer: opcode, pixel, end-of-image flag, filter load fields
    typedef struct packed {
        logic              op;
        logic              pix;
        logic              last;
        logic [FIDX_W-1:0] idx;
        logic [WIN_W-1:0]  weights;
        logic [THR_W-1:0]  thresh;
        logic              pol;
    } t_conv_in;

    // One output transfer
    typedef struct packed {
        logic [FEAT_W-1:0] feat;
        logic [POS_W-1:0]  pos;
        logic              last;
    } t_feat_res;

    // Directed row: item, and optionally the first result it must release
    typedef struct packed {
        t_conv_in  item;
        logic      checked;
        t_feat_res res;
    } t_dir_row;

    typedef struct packed {
        logic [WIN_W-1:0] weights;
        logic [THR_W-1:0] thresh;
        logic             pol;
    } t_filter;

    // Filters 0..2 pin the word's low bits, 3..15 fire only on an all-zero window:
    // a window holding any one gives 16'h0005, an empty one gives 16'hFFFD
    localparam int DIR_ROWS = 20;
    localparam t_dir_row DIR_TAB [DIR_ROWS] = '{
        '{'{OP_LOAD,  1'b0, 1'b0, 4'd0,  9'h000, 15'd9,     1'b0}, 1'b0, '0},
        '{'{OP_LOAD,  1'b0, 1'b0, 4'd1,  9'h1FF, 15'd32767, 1'b1}, 1'b0, '0},
        '{'{OP_LOAD,  1'b0, 1'b0, 4'd2,  9'h000, 15'd0,     1'b1}, 1'b0, '0},
        '{'{OP_LOAD,  1'b0, 1'b0, 4'd3,  9'h1FF, 15'd0,     1'b0}, 1'b0, '0},
        '{'{OP_LOAD,  1'b0, 1'b0, 4'd4,  9'h000, 15'd9,     1'b1}, 1'b0, '0},
        '{'{OP_LOAD,  1'b0, 1'b0, 4'd5,  9'h000, 15'd9,     1'b1}, 1'b0, '0},
        '{'{OP_LOAD,  1'b0, 1'b0, 4'd6,  9'h000, 15'd9,     1'b1}, 1'b0, '0},
        '{'{OP_LOAD,  1'b0, 1'b0, 4'd7,  9'h000, 15'd9,     1'b1}, 1'b0, '0},
        '{'{OP_LOAD,  1'b0, 1'b0, 4'd8,  9'h000, 15'd9,     1'b1}, 1'b0, '0},
        '{'{OP_LOAD,  1'b0, 1'b0, 4'd9,  9'h000, 15'd9,     1'b1}, 1'b0, '0},
        '{'{OP_LOAD,  1'b0, 1'b0, 4'd10, 9'h000, 15'd9,     1'b1}, 1'b0, '0},
        '{'{OP_LOAD,  1'b0, 1'b0, 4'd11, 9'h000, 15'd9,     1'b1}, 1'b0, '0},
        '{'{OP_LOAD,  1'b0, 1'b0, 4'd12, 9'h000, 15'd9,     1'b1}, 1'b0, '0},
        '{'{OP_LOAD,  1'b0, 1'b0, 4'd13, 9'h000, 15'd9,     1'b1}, 1'b0, '0},
        '{'{OP_LOAD,  1'b0, 1'b0, 4'd14, 9'h000, 15'd9,     1'b1}, 1'b0, '0},
        '{'{OP_LOAD,  1'b0, 1'b0, 4'd15, 9'h000, 15'd9,     1'b1}, 1'b0, '0},
        // single set pixel ends the image at once: flush releases positions 0..24
        '{'{OP_PIXEL, 1'b1, 1'b1, 4'd0,  9'h000, 15'd0,     1'b0}, 1'b1,
          '{16'h0005, 10'd0,  1'b0}},
        // pixels during the flush are dropped but still release the next batch
        '{'{OP_PIXEL, 1'b0, 1'b0, 4'd0,  9'h000, 15'd0,     1'b0}, 1'b1,
          '{16'h0005, 10'd25, 1'b0}},
        '{'{OP_PIXEL, 1'b1, 1'b1, 4'd0,  9'h000, 15'd0,     1'b0}, 1'b1,
          '{16'hFFFD, 10'd50, 1'b0}},
        // load during the flush, applied ahead of its batch
        '{'{OP_LOAD,  1'b0, 1'b0, 4'd5,  9'h000, 15'd9,     1'b1}, 1'b1,
          '{16'hFFFD, 10'd75, 1'b0}}
    };

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    // [0] pixel, [4:1] filter_index, [13:5] weight_bits, [28:14] threshold,
    // [29] polarity, [31:30] zero
    logic [31:0]       s_data  = '0;
    // [0] opcode
    logic              s_user  = 1'b0;
    logic              s_last  = 1'b0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    // [15:0] feature_word, [25:16] position, [31:26] zero
    logic [31:0]       m_data;
    logic              m_last;

    // Shared controls for the idling pattern and the long output hold-off
    bit                no_idle = 1'b0;
    bit                hold_go = 1'b0;
    int                err_cnt = 0;

    // Predictor state
    t_filter           filters [NUM_FILTERS];
    logic              line_up [IMG_WIDTH];
    logic              line_lo [IMG_WIDTH];
    logic [WIN_W-1:0]  nbhd;
    int unsigned       pixels_in;
    int unsigned       positions_out;
    bit                flushing;
    int                batch_len;
    t_feat_res         pending_features [$];

    binary_conv3x3_xnor_popcount uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .i_s_axis_tlast  (s_last),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tlast  (m_last)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #(LIMIT_NS);
        $display("DONE: errors detected");
        $finish;
    end

    task automatic report_err(input string msg);
        if (err_cnt < MAX_PRINTS) begin
            $display("ERROR %0t: %s", $time, msg);
        end
        err_cnt++;
    endtask

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    function automatic void restart_image();
        for (int c = 0; c < IMG_WIDTH; c++) begin
            line_up[c] = 1'b0;
            line_lo[c] = 1'b0;
        end
        nbhd          = '0;
        pixels_in     = 0;
        positions_out = 0;
        flushing      = 1'b0;
    endfunction

    // Mask the padding, run every filter over the window, queue the word
    function automatic void score_position(int unsigned q);
        int unsigned      r;
        int unsigned      c;
        int               cnt;
        logic [WIN_W-1:0] keep;
        logic [WIN_W-1:0] w;
        t_feat_res        res;
        r    = q / IMG_WIDTH;
        c    = q % IMG_WIDTH;
        keep = '1;
        if (r == 0) keep &= 9'b000_111_111;
        if (r == IMG_HEIGHT - 1) keep &= 9'b111_111_000;
        if (c == 0) keep &= 9'b011_011_011;
        if (c == IMG_WIDTH - 1) keep &= 9'b110_110_110;
        w        = nbhd & keep;
        res.feat = '0;
        for (int k = 0; k < NUM_LANES; k++) begin
            cnt = $countones(~(w ^ filters[k].weights));
            res.feat[k] = filters[k].pol ? (cnt >= int'(filters[k].thresh))
                                         : (cnt <= int'(filters[k].thresh));
        end
        res.pos  = POS_W'(q);
        res.last = (q == IMG_SIZE - 1);
        pending_features.push_back(res);
        batch_len++;
    endfunction

    // Advance line stores and window by one pixel; score the position it completes
    function automatic void shift_in_pixel(logic pix);
        int unsigned p;
        int unsigned col;
        int unsigned q;
        logic        up;
        logic        lo;
        p            = pixels_in;
        col          = p % IMG_WIDTH;
        up           = line_up[col];
        lo           = line_lo[col];
        line_up[col] = lo;
        line_lo[col] = pix;
        nbhd         = ((nbhd << 1) & 9'h1B6) | {2'b00, up, 2'b00, lo, 2'b00, pix};
        pixels_in    = p + 1;
        if (p >= IMG_WIDTH + 1) begin
            q = p - IMG_WIDTH - 1;
            if (q < IMG_SIZE && q == positions_out) begin
                score_position(q);
                positions_out = q + 1;
            end
        end
    endfunction

    // Push zero pixels until the batch is full or the image is complete
    function automatic void flush_image();
        while (batch_len < RESULT_CAP && positions_out < IMG_SIZE) begin
            shift_in_pixel(1'b0);
        end
        if (positions_out >= IMG_SIZE) restart_image();
    endfunction

    function automatic void compute_features(t_conv_in it);
        batch_len = 0;
        if (it.op == OP_LOAD && int'(it.idx) < NUM_FILTERS) begin
            filters[it.idx] = '{it.weights, it.thresh, it.pol};
        end
        if (flushing) begin
            flush_image();
        end else if (it.op == OP_PIXEL) begin
            shift_in_pixel(it.pix);
            if (it.last || pixels_in >= IMG_SIZE) begin
                flushing = 1'b1;
                flush_image();
            end
        end
    endfunction

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------

    function automatic t_conv_in random_item(logic op);
        t_conv_in it;
        it.op      = op;
        it.pix     = 1'($urandom_range(0, 1));
        it.last    = 1'($urandom_range(0, 1));
        it.idx     = FIDX_W'($urandom_range(0, NUM_FILTERS - 1));
        it.weights = WIN_W'($urandom_range(0, 511));
        case ($urandom_range(0, 9))
            0: it.thresh = '1;
            1: it.thresh = THR_W'($urandom());
            default: it.thresh = THR_W'($urandom_range(0, 10));
        endcase
        it.pol     = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // Offer one item, wait for the transfer, then predict its results
    task automatic send_item(input t_conv_in it, input logic checked, input t_feat_res res);
        int n_prior;
        while (!no_idle && $urandom_range(0, 99) < 13) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_user  <= it.op;
        s_last  <= it.last;
        s_data  <= {2'b00, it.pol, it.thresh, it.weights, it.idx, it.pix};
        do @(posedge i_clk); while (!s_ready);
        n_prior = pending_features.size();
        compute_features(it);
        if (checked) begin
            if (pending_features.size() > n_prior) begin
                pending_features[n_prior] = res;
            end else begin
                report_err("directed row released no result");
            end
        end
    endtask

    // Keep feeding loads and stray pixels until the flush completes
    task automatic finish_image(ref int sent);
        while (flushing) begin
            no_idle = (sent >= NO_IDLE_FROM && sent < NO_IDLE_TO);
            send_item(random_item(1'($urandom_range(0, 1))), 1'b0, '0);
            sent++;
        end
    endtask

    task automatic send_image(input int n_pix, input bit end_flag, ref int sent);
        int       density;
        t_conv_in it;
        density = $urandom_range(0, 100);
        for (int p = 0; p < n_pix; p++) begin
            no_idle = (sent >= NO_IDLE_FROM && sent < NO_IDLE_TO);
            if ($urandom_range(0, 9) == 0) begin
                send_item(random_item(OP_LOAD), 1'b0, '0);
                sent++;
            end
            it      = random_item(OP_PIXEL);
            it.pix  = ($urandom_range(0, 99) < density);
            it.last = end_flag && (p == n_pix - 1);
            send_item(it, 1'b0, '0);
            sent++;
        end
        finish_image(sent);
    endtask

    initial begin : stim
        int sent;
        int n_pix;
        sent = 0;
        restart_image();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows, then complete the flush they start
        for (int i = 0; i < DIR_ROWS; i++) begin
            send_item(DIR_TAB[i].item, DIR_TAB[i].checked, DIR_TAB[i].res);
        end
        finish_image(sent);

        // random images ended by tlast, mostly short
        while (sent < RAND_ITEMS) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: n_pix = $urandom_range(1, 30);
                4, 5, 6, 7: n_pix = $urandom_range(30, 90);
                default:    n_pix = $urandom_range(90, 250);
            endcase
            send_image(n_pix, 1'b1, sent);
        end
        no_idle = 1'b0;

        // short image with the receiver holding off meanwhile
        hold_go = 1'b1;
        send_image(TAIL_PIXELS, 1'b1, sent);
        s_valid <= 1'b0;

        // drain, then let the pipe settle
        while (pending_features.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // ---------------------------------------------------------------
    // Receiver and checker
    // ---------------------------------------------------------------

    // Stall at random; once, hold off long enough to back up the input
    initial begin : rx_side
        bit held;
        held = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_go && !held) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
            end
            m_ready <= no_idle || ($urandom_range(0, 99) >= 13);
        end
    end

    // Compare each output transfer with the oldest pending word
    always @(posedge i_clk) begin : result_check
        t_feat_res want;
        if (i_rst_n && m_valid && m_ready) begin
            if (pending_features.size() == 0) begin
                report_err($sformatf("unexpected result at position %0d", m_data[25:16]));
            end else begin
                want = pending_features.pop_front();
                if (m_data[15:0] !== want.feat) begin
                    report_err($sformatf("position %0d: feature word %h, want %h",
                                         want.pos, m_data[15:0], want.feat));
                end
                if (m_data[25:16] !== want.pos) begin
                    report_err($sformatf("position %0d, want %0d", m_data[25:16], want.pos));
                end
                if (m_last !== want.last) begin
                    report_err($sformatf("position %0d: last %b, want %b",
                                         want.pos, m_last, want.last));
                end
            end
        end
    end

endmodule
